// ===== sv/bmr_pkg.sv =====
// bmr_pkg: shared constants and types for the bounded MT random unit.
// No dependencies.
package bmr_pkg;
    localparam int unsigned MtN = 624;
    localparam int unsigned MtM = 397;
    localparam int unsigned AddrW = 10;
    localparam logic [31:0] MT_MATRIX   = 32'h9908b0df;
    localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [31:0] TEMPER_B    = 32'hff3a58ad;
    localparam logic [31:0] TEMPER_C    = 32'hffffdf8c;
    localparam logic [31:0] SEED_RESET  = 32'd5489;
    localparam logic [AddrW-1:0] LAST_IDX = AddrW'(MtN - 1);
    localparam logic [AddrW-1:0] N_IDX    = AddrW'(MtN);

    typedef enum logic [4:0] {
        S_INIT_MUL, S_INIT_WR, S_IDLE, S_DECIDE,
        S_TW_RD0, S_TW_RD1, S_TW_RD2, S_TW_WR,
        S_DR_RD, S_DR_WAIT, S_TEMPER, S_POW2, S_MOD, S_CHECK, S_OUT
    } t_state;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y & TEMPER_B) << 7);
        y = y ^ ((y & TEMPER_C) << 15);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage

// ===== sv/bmr_ram.sv =====
// bmr_ram: 624 x 32 single-port state memory, registered read.
// Depends on bmr_pkg.
module bmr_ram
    import bmr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_addr,
    input  logic [31:0]      i_wdata,
    output logic [31:0]      o_rdata
);
    logic [31:0] r_mem [MtN];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== sv/bmr_divider.sv =====
// bmr_divider: serial restoring 31-by-32 remainder, one bit per cycle.
// Depends on bmr_pkg.
module bmr_divider
    import bmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [30:0] r_num;
    logic [32:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    assign w_sh = {r_rem[31:0], r_num[30]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[29:0], 1'b0};
                r_rem <= (w_sh >= {1'b0, i_den}) ? w_sh - {1'b0, i_den} : w_sh;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_rem = r_rem[31:0];
endmodule

// ===== sv/bounded_mt_random_unit.sv =====
// bounded_mt_random_unit: MT19937 bounded integers by rejection sampling.
// Nonpositive bounds skip the draw; powers of two take a multiply; other bounds
// use the serial remainder, redrawn on each rejection. A twist every 624 draws
// adds four memory accesses per word on the single port. One request at a
// time; the next is taken while a result waits.
// Reset (synchronous, active low) runs a seeding pass; no request is taken
// during it. A seed write restarts that pass.
module bounded_mt_random_unit
    import bmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_bound,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_value,
    output logic [31:0] o_draw_count,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    t_state r_state, n_state;
    logic [AddrW-1:0] r_idx, r_k;      // word index, sweep pointer
    logic [31:0] r_prev, r_a, r_b, r_bound, r_count, r_d;
    logic [31:0] r_seed;               // seed register
    logic [30:0] r_v;
    logic        r_pend;               // seed write waiting

    logic             ram_we;
    logic [AddrW-1:0] ram_addr;
    logic [31:0]      ram_wdata, ram_rdata;

    bmr_ram u_ram (.i_clk, .i_we(ram_we), .i_addr(ram_addr),
                   .i_wdata(ram_wdata), .o_rdata(ram_rdata));

    // tempered word of the raw draw held in r_d
    logic [31:0] w_temp;
    assign w_temp = temper(r_d);

    logic        div_start, div_done;
    logic [31:0] div_rem;
    bmr_divider u_div (.i_clk, .i_rst_n, .i_start(div_start), .i_num(w_temp[31:1]),
                       .i_den(r_bound), .o_done(div_done), .o_rem(div_rem));

    logic [AddrW-1:0] w_k1, w_km;
    logic [31:0] w_y, w_x, w_chk;
    logic [62:0] w_prod;
    logic        w_load;               // result register takes a new result
    assign w_k1 = (r_k == LAST_IDX) ? '0 : r_k + 1'b1;
    assign w_km = (r_k >= AddrW'(MtN - MtM)) ? r_k - AddrW'(MtN - MtM)
                                             : r_k + AddrW'(MtM);
    assign w_y  = {r_a[31], r_b[30:0]};
    assign w_x  = ram_rdata ^ (w_y >> 1) ^ (w_y[0] ? MT_MATRIX : 32'd0);
    assign w_prod = r_d[30:0] * r_bound;
    assign w_chk = r_d - div_rem + r_bound - 32'd1;
    assign w_load = (r_state == S_OUT) && (!o_valid || i_ready);

    assign o_ready = (r_state == S_IDLE) && !r_pend;

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = r_k;
        ram_wdata = r_prev;
        div_start = 1'b0;
        case (r_state)
            S_INIT_MUL: n_state = S_INIT_WR;
            S_INIT_WR: begin
                ram_we = 1'b1;
                if (r_k == LAST_IDX) n_state = S_IDLE;
                else n_state = S_INIT_MUL;
            end
            S_IDLE: begin
                if (r_pend) n_state = S_INIT_WR;
                else if (i_valid && o_ready) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_bound[31] || r_bound == 32'd0) n_state = S_OUT;
                else if (r_idx >= N_IDX) n_state = S_TW_RD0;
                else n_state = S_DR_RD;
            end
            S_TW_RD0: n_state = S_TW_RD1;
            S_TW_RD1: begin ram_addr = w_k1; n_state = S_TW_RD2; end
            S_TW_RD2: begin ram_addr = w_km; n_state = S_TW_WR; end
            S_TW_WR: begin
                ram_we = 1'b1;
                ram_wdata = w_x;
                n_state = (r_k == LAST_IDX) ? S_DR_RD : S_TW_RD0;
            end
            S_DR_RD: begin ram_addr = r_idx; n_state = S_DR_WAIT; end
            S_DR_WAIT: n_state = S_TEMPER;
            S_TEMPER: begin
                if ((r_bound & (~r_bound + 32'd1)) == r_bound) n_state = S_POW2;
                else begin div_start = 1'b1; n_state = S_MOD; end
            end
            S_POW2: n_state = S_OUT;
            S_MOD: if (div_done) n_state = S_CHECK;
            S_CHECK: begin
                // rejected draw: fetch another, twisting first if used up
                if (w_chk[31]) n_state = (r_idx >= N_IDX) ? S_TW_RD0 : S_DR_RD;
                else n_state = S_OUT;
            end
            S_OUT: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_WR;
            r_k     <= '0;
            r_prev  <= SEED_RESET;
            r_seed  <= SEED_RESET;
            r_idx   <= N_IDX;
            r_count <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                o_valid      <= 1'b1;
                o_value      <= r_v;
                o_draw_count <= r_count;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_pend <= 1'b1;
                r_seed <= i_cfg_wdata;
            end
            case (r_state)
                S_INIT_MUL: r_prev <= MT_INIT_MUL * (r_prev ^ (r_prev >> 30)) + 32'(r_k);
                S_INIT_WR: if (r_k != LAST_IDX) r_k <= r_k + 1'b1;
                S_IDLE: begin
                    if (r_pend) begin
                        if (!i_cfg_we) r_pend <= 1'b0;
                        r_k     <= '0;
                        r_prev  <= r_seed;
                        r_idx   <= N_IDX;
                    end
                    r_bound <= i_bound;
                end
                S_DECIDE: begin
                    r_k <= '0;
                    if (!(r_bound[31] || r_bound == 32'd0)) r_count <= r_count + 32'd1;
                    r_v <= '0;
                end
                S_TW_RD1: r_a <= ram_rdata;
                S_TW_RD2: r_b <= ram_rdata;
                S_TW_WR: if (r_k == LAST_IDX) r_idx <= '0; else r_k <= r_k + 1'b1;
                S_DR_RD: r_idx <= r_idx + 1'b1;
                S_DR_WAIT: r_d <= ram_rdata;
                S_TEMPER: r_d <= {1'b0, w_temp[31:1]};
                S_POW2: r_v <= w_prod[61:31];
                S_CHECK: begin
                    r_v <= div_rem[30:0];
                    if (w_chk[31]) r_k <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule
